### design/pfrr_pkg.sv
// Shared constants, codes and types for the random page replacer.
package pfrr_pkg;

  localparam int unsigned MaxPages  = 64;
  localparam int unsigned MaxFrames = 16;
  localparam int unsigned PageW     = $clog2(MaxPages);
  localparam int unsigned FrameW    = $clog2(MaxFrames);
  localparam int unsigned PagesCfgW = 7;
  localparam int unsigned FramesCfgW = 5;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned PickW     = 16;
  localparam int unsigned PickCntW  = $clog2(PickW);
  localparam int unsigned DiskW     = 32;
  localparam int unsigned StatusW   = 3;

  localparam logic [CfgIdxW-1:0] CfgPagesInUse  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFramesInUse = 1'b1;

  localparam logic [PagesCfgW-1:0]  PagesReset  = PagesCfgW'(MaxPages);
  localparam logic [FramesCfgW-1:0] FramesReset = FramesCfgW'(MaxFrames);

  localparam logic FuncFault = 1'b0;
  localparam logic FuncDirty = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StFree     = 3'd0,
    StReplaced = 3'd1,
    StResident = 3'd2,
    StDirty    = 3'd3,
    StError    = 3'd4
  } status_e;

endpackage

### design/pfrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/page_fault_random_replacer.sv
// Top level of the demand-paging page table with random frame replacement.

// A request is taken when start_i is high and busy_o is low; its single result
// appears with done_o for one cycle and cannot be held off. An out-of-range,
// resident or dirty-mark request, or a fault with no frames in use, ends in the
// Lookup state. A fault that finds a free frame ends in the scan of the frame
// table one frame per cycle. A fault that must replace a page runs the full scan,
// then a 16-step bit-serial remainder of the random pick by the frame count, then
// the Replace state's update. The page-to-frame table lives in a RAM read as the
// request is taken, so its data is ready in Lookup.
module page_fault_random_replacer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfrr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pfrr_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic [pfrr_pkg::PageW-1:0]        page_number_i,
  input  logic [pfrr_pkg::PickW-1:0]        victim_pick_i,
  output logic                              done_o,
  output logic [pfrr_pkg::FrameW-1:0]       frame_number_o,
  output logic [pfrr_pkg::PageW-1:0]        victim_page_o,
  output logic                              evicted_o,
  output logic                              write_back_o,
  output logic [pfrr_pkg::DiskW-1:0]        disk_accesses_o,
  output logic [pfrr_pkg::StatusW-1:0]      status_o
);
  import pfrr_pkg::*;

  typedef enum logic [2:0] {
    Idle,
    Lookup,
    Scan,
    Divide,
    Replace
  } state_e;

  state_e                 state_q;
  logic [PagesCfgW-1:0]   pages_cfg_q;
  logic [FramesCfgW-1:0]  frames_cfg_q;
  logic                   func_q;
  logic [PageW-1:0]       page_q;
  logic [PickW-1:0]       pick_q;
  logic [FramesCfgW-1:0]  scan_q;
  logic [FramesCfgW-1:0]  rem_q;
  logic [PickCntW-1:0]    step_q;
  logic [MaxPages-1:0]    page_valid_q;
  logic [MaxPages-1:0]    page_dirty_q;
  logic [MaxFrames-1:0]   frame_occ_q;
  logic [PageW-1:0]       frame_owner_q [MaxFrames];
  logic [DiskW-1:0]       disk_q;

  logic                   done_q;
  logic [FrameW-1:0]      frame_q;
  logic [PageW-1:0]       victim_q;
  logic                   evicted_q;
  logic                   wb_q;
  status_e                status_q;

  logic [FramesCfgW-1:0]  nf;
  logic                   page_in_range;
  logic [FramesCfgW-1:0]  rem_shift;
  logic [FramesCfgW-1:0]  rem_d;
  logic [FrameW-1:0]      rem_frame;
  logic [PageW-1:0]       victim_page;
  logic                   ram_we;
  logic [FrameW-1:0]      ram_wdata;
  logic [PageW-1:0]       ram_raddr;
  logic [FrameW-1:0]      ram_rdata;

  assign nf = (frames_cfg_q > FramesReset) ? FramesReset : frames_cfg_q;
  assign page_in_range = (pages_cfg_q >= PagesReset) ||
                         (page_q < pages_cfg_q[PageW-1:0]);
  assign rem_shift = {rem_q[FramesCfgW-2:0], pick_q[PickW-1]};
  assign rem_d = (rem_shift >= nf) ? (rem_shift - nf) : rem_shift;
  assign rem_frame = rem_q[FrameW-1:0];
  assign victim_page = frame_owner_q[rem_frame];

  assign ram_raddr = (state_q == Idle) ? page_number_i : page_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rem_frame;
    unique case (state_q)
      Scan: begin
        ram_we    = (scan_q != nf) && !frame_occ_q[scan_q[FrameW-1:0]];
        ram_wdata = scan_q[FrameW-1:0];
      end
      Replace: begin
        ram_we    = 1'b1;
        ram_wdata = rem_frame;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = rem_frame;
      end
    endcase
  end

  pfrr_ram #(
    .Width (FrameW),
    .Depth (MaxPages)
  ) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (page_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Idle;
      pages_cfg_q  <= PagesReset;
      frames_cfg_q <= FramesReset;
      func_q       <= FuncFault;
      page_q       <= '0;
      pick_q       <= '0;
      scan_q       <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      page_valid_q <= '0;
      page_dirty_q <= '0;
      frame_occ_q  <= '0;
      disk_q       <= '0;
      done_q       <= 1'b0;
      frame_q      <= '0;
      victim_q     <= '0;
      evicted_q    <= 1'b0;
      wb_q         <= 1'b0;
      status_q     <= StFree;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPagesInUse:  pages_cfg_q  <= cfg_wdata_i[PagesCfgW-1:0];
          CfgFramesInUse: frames_cfg_q <= cfg_wdata_i[FramesCfgW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        Idle: begin
          if (start_i) begin
            func_q  <= func_i;
            page_q  <= page_number_i;
            pick_q  <= victim_pick_i;
            state_q <= Lookup;
          end
        end
        Lookup: begin
          frame_q   <= '0;
          victim_q  <= '0;
          evicted_q <= 1'b0;
          wb_q      <= 1'b0;
          if (!page_in_range) begin
            status_q <= StError;
            done_q   <= 1'b1;
            state_q  <= Idle;
          end else if (func_q == FuncDirty) begin
            done_q  <= 1'b1;
            state_q <= Idle;
            if (page_valid_q[page_q]) begin
              page_dirty_q[page_q] <= 1'b1;
              frame_q              <= ram_rdata;
              status_q             <= StDirty;
            end else begin
              status_q <= StError;
            end
          end else if (page_valid_q[page_q]) begin
            frame_q  <= ram_rdata;
            status_q <= StResident;
            done_q   <= 1'b1;
            state_q  <= Idle;
          end else if (nf == '0) begin
            status_q <= StError;
            done_q   <= 1'b1;
            state_q  <= Idle;
          end else begin
            scan_q  <= '0;
            state_q <= Scan;
          end
        end
        Scan: begin
          if (scan_q == nf) begin
            rem_q   <= '0;
            step_q  <= '1;
            state_q <= Divide;
          end else if (!frame_occ_q[scan_q[FrameW-1:0]]) begin
            frame_occ_q[scan_q[FrameW-1:0]]   <= 1'b1;
            frame_owner_q[scan_q[FrameW-1:0]] <= page_q;
            page_valid_q[page_q]              <= 1'b1;
            disk_q                            <= disk_q + DiskW'(1);
            frame_q                           <= scan_q[FrameW-1:0];
            status_q                          <= StFree;
            done_q                            <= 1'b1;
            state_q                           <= Idle;
          end else begin
            scan_q <= scan_q + FramesCfgW'(1);
          end
        end
        Divide: begin
          rem_q  <= rem_d;
          pick_q <= {pick_q[PickW-2:0], 1'b0};
          step_q <= step_q - PickCntW'(1);
          if (step_q == '0) begin
            state_q <= Replace;
          end
        end
        Replace: begin
          page_valid_q[victim_page] <= 1'b0;
          page_dirty_q[victim_page] <= 1'b0;
          page_valid_q[page_q]      <= 1'b1;
          frame_owner_q[rem_frame]  <= page_q;
          disk_q    <= disk_q + (page_dirty_q[victim_page] ? DiskW'(2) : DiskW'(1));
          frame_q   <= rem_frame;
          victim_q  <= victim_page;
          evicted_q <= 1'b1;
          wb_q      <= page_dirty_q[victim_page];
          status_q  <= StReplaced;
          done_q    <= 1'b1;
          state_q   <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign busy_o          = (state_q != Idle);
  assign done_o          = done_q;
  assign frame_number_o  = frame_q;
  assign victim_page_o   = victim_q;
  assign evicted_o       = evicted_q;
  assign write_back_o    = wb_q;
  assign disk_accesses_o = disk_q;
  assign status_o        = status_q;

endmodule
